/* src/mipd_pkg.sv */
package mipd_pkg;

  // major opcodes
  localparam logic [5:0] OpSpecial  = 6'h00;
  localparam logic [5:0] OpRegimm   = 6'h01;
  localparam logic [5:0] OpJ        = 6'h02;
  localparam logic [5:0] OpJal      = 6'h03;
  localparam logic [5:0] OpBeq      = 6'h04;
  localparam logic [5:0] OpBgtz     = 6'h07;
  localparam logic [5:0] OpSpecial2 = 6'h1C;
  localparam logic [5:0] OpJalx     = 6'h1D;
  localparam logic [5:0] OpLb       = 6'h20;
  localparam logic [5:0] OpLh       = 6'h21;
  localparam logic [5:0] OpLbu      = 6'h24;
  localparam logic [5:0] OpLhu      = 6'h25;
  localparam logic [5:0] OpLwr      = 6'h26;
  localparam logic [5:0] OpSb       = 6'h28;
  localparam logic [5:0] OpSh       = 6'h29;
  localparam logic [5:0] OpSw       = 6'h2B;
  localparam logic [5:0] OpLl       = 6'h30;
  localparam logic [5:0] OpLd       = 6'h38;
  localparam logic [5:0] OpSq       = 6'h3C;
  localparam logic [5:0] OpSdc2     = 6'h3E;

  // function codes
  localparam logic [5:0] FnJr       = 6'h08;
  localparam logic [5:0] FnJalr     = 6'h09;
  localparam logic [5:0] FnS2Branch = 6'h02;

  localparam logic [4:0]  RegRa       = 5'd31;
  localparam logic [4:0]  RegZero     = 5'd0;
  localparam logic [31:0] SyscallWord = 32'h0000_000C;

  // configuration register indexes
  localparam logic CfgCodeStart = 1'b0;
  localparam logic CfgCodeEnd   = 1'b1;

  // io window codes
  localparam logic [3:0] IoNone    = 4'd0;
  localparam logic [3:0] IoWin1    = 4'd1;
  localparam logic [3:0] IoWin2    = 4'd2;
  localparam logic [3:0] IoWin3    = 4'd3;
  localparam logic [3:0] IoWin4    = 4'd4;
  localparam logic [3:0] IoWin5    = 4'd5;
  localparam logic [3:0] IoWin6    = 4'd6;
  localparam logic [3:0] IoWin7    = 4'd7;
  localparam logic [3:0] IoWin8    = 4'd8;
  localparam logic [3:0] IoWin9    = 4'd9;

  typedef enum logic [1:0] {
    MemNone  = 2'd0,
    MemLoad  = 2'd1,
    MemStore = 2'd2
  } mem_op_e;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] word;
    logic [31:0] func_lo;
    logic [31:0] func_hi;
    logic [31:0] rs_value;
  } item_t;

  typedef struct packed {
    logic        call_found;
    logic [31:0] call_addr;
    logic        local_target_valid;
    logic [31:0] local_target;
    logic        syscall_found;
    logic        return_found;
    mem_op_e     mem_op;
    logic [2:0]  access_bytes;
    logic [31:0] effective_addr;
    logic [4:0]  base_index;
    logic [3:0]  io_region;
  } result_t;

  // first matching window wins
  // windows with set bits below their mask never match and fold away
  function automatic logic [3:0] io_code(input logic [31:0] a);
    logic [31:0] h;
    logic [31:0] b;
    logic [3:0]  code;
    h = a & 32'hFFFF_0000;
    b = a & 32'hFF00_0000;
    if (h == 32'h1000_0000)                         code = IoWin1;
    else if (h == 32'h1000_F000)                    code = IoWin2;
    else if (b == 32'h1D00_0000)                    code = IoWin3;
    else if (b == 32'h1C00_0000)                    code = IoWin4;
    else if (h == 32'h1000_2000)                    code = IoWin5;
    else if (h == 32'h1000_3000)                    code = IoWin6;
    else if (h == 32'h1000_4000)                    code = IoWin7;
    else if (h == 32'h1000_5000)                    code = IoWin8;
    else if ((a & 32'hFFFF_F000) == 32'h1000_F100)  code = IoWin9;
    else                                            code = IoNone;
    return code;
  endfunction

endpackage

/* src/mips_instruction_predecoder_core.sv */
// path: an accepted word is held in the input register, then its decode is stored in the result register
// throughput: one word per cycle while the output is ready, decode is a single pass between the two registers
// the input stage refills while the result register drains, so a waiting result
// only stalls input once both stages hold a word
// reset: both stages empty, code region start and end cleared to 0
module mips_instruction_predecoder_core
  import mipd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_pc_i,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] func_lo_i,
  input  logic [31:0] func_hi_i,
  input  logic [31:0] rs_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        call_found_o,
  output logic [31:0] call_addr_o,
  output logic        local_target_valid_o,
  output logic [31:0] local_target_o,
  output logic        syscall_found_o,
  output logic        return_found_o,
  output logic [1:0]  mem_op_o,
  output logic [2:0]  access_bytes_o,
  output logic [31:0] effective_addr_o,
  output logic [4:0]  base_index_o,
  output logic [3:0]  io_region_o
);

  logic [31:0] code_start_q;
  logic [31:0] code_end_q;
  logic        in_valid_q, in_valid_d;
  item_t       item_q;
  logic        out_valid_q, out_valid_d;
  result_t     res_q;
  result_t     res_d;
  logic        adv;
  logic        in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_start_q <= '0;
      code_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgCodeStart: code_start_q <= cfg_data_i;
        CfgCodeEnd:   code_end_q   <= cfg_data_i;
        default:      code_end_q   <= code_end_q;
      endcase
    end
  end

  // result stage can take a new word when empty or being drained
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = adv ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{pc: instr_pc_i, word: instr_word_i, func_lo: func_lo_i,
                  func_hi: func_hi_i, rs_value: rs_value_i};
    end
    if (adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  mipd_decode u_decode (
    .item_i      (item_q),
    .code_start_i(code_start_q),
    .code_end_i  (code_end_q),
    .res_o       (res_d)
  );

  assign out_valid_o          = out_valid_q;
  assign call_found_o         = res_q.call_found;
  assign call_addr_o          = res_q.call_addr;
  assign local_target_valid_o = res_q.local_target_valid;
  assign local_target_o       = res_q.local_target;
  assign syscall_found_o      = res_q.syscall_found;
  assign return_found_o       = res_q.return_found;
  assign mem_op_o             = res_q.mem_op;
  assign access_bytes_o       = res_q.access_bytes;
  assign effective_addr_o     = res_q.effective_addr;
  assign base_index_o         = res_q.base_index;
  assign io_region_o          = res_q.io_region;

  // a word held in the input stage moves on as soon as the result stage frees up
  a_input_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && adv && !in_fire |=> out_valid_q && !in_valid_q)
    else $error("input stage did not drain");

  a_no_call_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !call_found_o |-> call_addr_o == 32'd0)
    else $error("call address set without a call");

  a_no_local_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !local_target_valid_o |-> local_target_o == 32'd0)
    else $error("local target set without a valid target");

  a_mem_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((mem_op_o == MemNone) == (access_bytes_o == 3'd0)))
    else $error("access size disagrees with memory op");

endmodule

/* src/mipd_decode.sv */
module mipd_decode
  import mipd_pkg::*;
(
  input  item_t       item_i,
  input  logic [31:0] code_start_i,
  input  logic [31:0] code_end_i,
  output result_t     res_o
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rd;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [31:0] imm_sext;
  logic [31:0] region_tgt;
  logic [31:0] branch_tgt;
  logic [31:0] ea;
  logic        is_branch;
  logic        is_jump;
  logic [31:0] tgt;
  logic        tgt_local;
  mem_op_e     mem_op;
  logic [2:0]  bytes;

  assign op = item_i.word[31:26];
  assign fn = item_i.word[5:0];
  assign rd = item_i.word[15:11];
  assign rs = item_i.word[25:21];
  assign rt = item_i.word[20:16];

  assign imm_sext   = {{16{item_i.word[15]}}, item_i.word[15:0]};
  assign region_tgt = {item_i.pc[31:28], item_i.word[25:0], 2'b00};
  assign branch_tgt = item_i.pc + 32'd4 + {imm_sext[29:0], 2'b00};
  assign ea         = item_i.rs_value + imm_sext;

  always_comb begin
    is_branch = 1'b0;
    if (op inside {[OpBeq:OpBgtz]}) begin
      is_branch = 1'b1;
    end else if (op == OpRegimm && (rt inside {[5'h00:5'h03], [5'h10:5'h13]})) begin
      is_branch = 1'b1;
    end else if (op == OpSpecial && (fn == FnJr || fn == FnJalr)) begin
      is_branch = 1'b1;
    end else if (op == OpSpecial2 && fn == FnS2Branch) begin
      is_branch = 1'b1;
    end
  end

  // jalx is a call but not a local jump
  assign is_jump = (op == OpJ) || (op == OpJal);

  always_comb begin
    tgt = 32'd0;
    if (is_branch) begin
      // register jumps carry a zero target
      tgt = (op == OpSpecial) ? 32'd0 : branch_tgt;
    end else if (is_jump) begin
      tgt = region_tgt;
    end
  end

  assign tgt_local = (is_branch || is_jump) && (tgt >= item_i.func_lo) &&
                     (tgt < item_i.func_hi);

  always_comb begin
    mem_op = MemNone;
    if (op inside {[OpLb:OpLwr], OpLl, OpLd}) begin
      mem_op = MemLoad;
    end else if (op inside {[OpSb:OpSw], OpSq, OpSdc2}) begin
      mem_op = MemStore;
    end
  end

  always_comb begin
    case (op)
      OpLb, OpLbu, OpSb: bytes = 3'd1;
      OpLh, OpLhu, OpSh: bytes = 3'd2;
      OpLwr:             bytes = 3'd3;
      default:           bytes = 3'd4;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (op == OpJal || op == OpJalx) begin
      res_o.call_found = 1'b1;
      res_o.call_addr  = region_tgt;
    end else if (op == OpSpecial && fn == FnJalr && rd == RegRa &&
                 item_i.rs_value >= code_start_i && item_i.rs_value < code_end_i) begin
      res_o.call_found = 1'b1;
      res_o.call_addr  = item_i.rs_value;
    end
    if (tgt_local) begin
      res_o.local_target_valid = 1'b1;
      res_o.local_target       = tgt;
    end
    res_o.syscall_found = (item_i.word == SyscallWord);
    res_o.return_found  = (op == OpSpecial) && (fn == FnJr) && (rd == RegZero);
    res_o.mem_op        = mem_op;
    if (mem_op != MemNone) begin
      res_o.access_bytes   = bytes;
      res_o.effective_addr = ea;
      res_o.base_index     = rs;
      res_o.io_region      = io_code(ea);
    end
  end

endmodule

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mipd_pkg::*;

  // opcodes and regimm selectors that the package leaves unnamed
  localparam logic [5:0] OpBne     = 6'h05;
  localparam logic [5:0] OpBlez    = 6'h06;
  localparam logic [5:0] OpLwl     = 6'h22;
  localparam logic [5:0] OpLw      = 6'h23;
  localparam logic [5:0] OpSwl     = 6'h2A;
  localparam logic [4:0] RtBgezl   = 5'h03;
  localparam logic [4:0] RtBltzal  = 5'h10;
  localparam logic [4:0] RtBgezall = 5'h13;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } plan_row_t;

  typedef struct {
    item_t   stim;
    result_t want;
  } decode_rec_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic        cfg_index_i  = CfgCodeStart;
  logic [31:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [31:0] instr_pc_i   = '0;
  logic [31:0] instr_word_i = '0;
  logic [31:0] func_lo_i    = '0;
  logic [31:0] func_hi_i    = '0;
  logic [31:0] rs_value_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        call_found_o;
  logic [31:0] call_addr_o;
  logic        local_target_valid_o;
  logic [31:0] local_target_o;
  logic        syscall_found_o;
  logic        return_found_o;
  logic [1:0]  mem_op_o;
  logic [2:0]  access_bytes_o;
  logic [31:0] effective_addr_o;
  logic [4:0]  base_index_o;
  logic [3:0]  io_region_o;

  logic [31:0]  region_first = '0;
  logic [31:0]  region_past  = '0;
  bit           steady_flow = 1'b0;
  int unsigned  fault_count = 0;
  decode_rec_t  pending_decodes[$];
  plan_row_t    plan[$];

  logic [5:0] op_menu [25] = '{
    OpSpecial, OpRegimm, OpJ, OpJal, OpBeq, OpBne, OpBlez, OpBgtz, OpSpecial2, OpJalx,
    OpLb, OpLh, OpLwl, OpLw, OpLbu, OpLhu, OpLwr, OpLl, OpLd,
    OpSb, OpSh, OpSwl, OpSw, OpSq, OpSdc2
  };

  mips_instruction_predecoder_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [31:0] enc_imm(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_reg(input logic [4:0] rs, input logic [4:0] rd,
                                          input logic [5:0] fn);
    return {OpSpecial, rs, 5'd0, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] enc_jump(input logic [5:0] op, input logic [25:0] index);
    return {op, index};
  endfunction

  function automatic logic [31:0] far_dest(input logic [31:0] pc, input logic [31:0] word);
    return {pc[31:28], word[25:0], 2'b00};
  endfunction

  // branch or jump destination, register jumps land on zero
  function automatic logic flow_dest(input logic [31:0] pc, input logic [31:0] word,
                                     output logic [31:0] dest);
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rt;
    logic       branch;
    op = word[31:26];
    fn = word[5:0];
    rt = word[20:16];
    branch = (op >= OpBeq && op <= OpBgtz)
          || (op == OpRegimm && (rt <= RtBgezl || (rt >= RtBltzal && rt <= RtBgezall)))
          || (op == OpSpecial && (fn == FnJr || fn == FnJalr))
          || (op == OpSpecial2 && fn == FnS2Branch);
    dest = '0;
    if (branch) begin
      if (op != OpSpecial) dest = pc + 32'd4 + {{14{word[15]}}, word[15:0], 2'b00};
      return 1'b1;
    end
    if (op == OpJ || op == OpJal) begin
      dest = far_dest(pc, word);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // first matching window wins
  function automatic logic [3:0] io_window(input logic [31:0] a);
    if ((a & 32'hFFFF_0000) == 32'h1000_0000) return IoWin1;
    if ((a & 32'hFFFF_0000) == 32'h1000_F000) return IoWin2;
    if ((a & 32'hFF00_0000) == 32'h1D00_0000) return IoWin3;
    if ((a & 32'hFF00_0000) == 32'h1C00_0000) return IoWin4;
    if ((a & 32'hFFFF_0000) == 32'h1000_2000) return IoWin5;
    if ((a & 32'hFFFF_0000) == 32'h1000_3000) return IoWin6;
    if ((a & 32'hFFFF_0000) == 32'h1000_4000) return IoWin7;
    if ((a & 32'hFFFF_0000) == 32'h1000_5000) return IoWin8;
    if ((a & 32'hFFFF_F000) == 32'h1000_F100) return IoWin9;
    return IoNone;
  endfunction

  function automatic result_t decode_word(input item_t it);
    result_t     r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rd;
    logic [31:0] dest;
    mem_op_e     kind;
    logic [2:0]  nbytes;
    r  = '0;
    op = it.word[31:26];
    fn = it.word[5:0];
    rd = it.word[15:11];
    if (op == OpJal || op == OpJalx) begin
      r.call_found = 1'b1;
      r.call_addr  = far_dest(it.pc, it.word);
    end else if (op == OpSpecial && fn == FnJalr && rd == RegRa
                 && it.rs_value >= region_first && it.rs_value < region_past) begin
      r.call_found = 1'b1;
      r.call_addr  = it.rs_value;
    end
    if (flow_dest(it.pc, it.word, dest) && dest >= it.func_lo && dest < it.func_hi) begin
      r.local_target_valid = 1'b1;
      r.local_target       = dest;
    end
    r.syscall_found = (it.word == SyscallWord);
    r.return_found  = (op == OpSpecial && fn == FnJr && rd == RegZero);
    kind   = MemNone;
    nbytes = 3'd0;
    case (op)
      OpLb, OpLbu: begin
        kind = MemLoad; nbytes = 3'd1;
      end
      OpLh, OpLhu: begin
        kind = MemLoad; nbytes = 3'd2;
      end
      OpLwr: begin
        kind = MemLoad; nbytes = 3'd3;
      end
      OpLwl, OpLw, OpLl, OpLd: begin
        kind = MemLoad; nbytes = 3'd4;
      end
      OpSb: begin
        kind = MemStore; nbytes = 3'd1;
      end
      OpSh: begin
        kind = MemStore; nbytes = 3'd2;
      end
      OpSwl, OpSw, OpSq, OpSdc2: begin
        kind = MemStore; nbytes = 3'd4;
      end
      default: ;
    endcase
    if (kind != MemNone) begin
      r.mem_op         = kind;
      r.access_bytes   = nbytes;
      r.effective_addr = it.rs_value + {{16{it.word[15]}}, it.word[15:0]};
      r.base_index     = it.word[25:21];
      r.io_region      = io_window(r.effective_addr);
    end
    return r;
  endfunction

  function automatic result_t result_of(
      input logic call, input logic [31:0] caddr, input logic lv, input logic [31:0] lt,
      input logic sys, input logic ret, input mem_op_e kind, input logic [2:0] nbytes,
      input logic [31:0] ea, input logic [4:0] base, input logic [3:0] io);
    result_t r;
    r.call_found         = call;
    r.call_addr          = caddr;
    r.local_target_valid = lv;
    r.local_target       = lt;
    r.syscall_found      = sys;
    r.return_found       = ret;
    r.mem_op             = kind;
    r.access_bytes       = nbytes;
    r.effective_addr     = ea;
    r.base_index         = base;
    r.io_region          = io;
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("call=%b/%h tgt=%b/%h sys=%b ret=%b mem=%0d/%0d ea=%h base=%0d io=%0d",
                     r.call_found, r.call_addr, r.local_target_valid, r.local_target,
                     r.syscall_found, r.return_found, r.mem_op, r.access_bytes,
                     r.effective_addr, r.base_index, r.io_region);
  endfunction

  task automatic add_row(input logic [31:0] pc, input logic [31:0] word,
                         input logic [31:0] lo, input logic [31:0] hi,
                         input logic [31:0] rsv, input bit typed, input result_t want);
    plan_row_t row;
    row.stim  = '{pc: pc, word: word, func_lo: lo, func_hi: hi, rs_value: rsv};
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endtask

  function automatic item_t forge_item();
    item_t       it;
    logic [5:0]  op;
    logic [31:0] dest;
    it.pc       = $urandom;
    it.word     = $urandom;
    it.func_lo  = $urandom;
    it.func_hi  = $urandom;
    it.rs_value = $urandom;
    if ($urandom_range(99) < 85) begin
      op = op_menu[$urandom_range(24)];
      it.word[31:26] = op;
      if ($urandom_range(1)) it.word[15:0] = 16'($urandom_range(255)) - 16'd128;
      if (op == OpSpecial && $urandom_range(4) != 0) begin
        it.word[5:0] = $urandom_range(1) ? FnJr : FnJalr;
        if ($urandom_range(1)) it.word[15:11] = $urandom_range(1) ? RegRa : RegZero;
      end
      if (op == OpSpecial2 && $urandom_range(3) != 0) it.word[5:0] = FnS2Branch;
      if (op == OpRegimm && $urandom_range(1))
        it.word[20:16] = {1'($urandom_range(1)), 2'b00, 2'($urandom_range(3))};
      if ($urandom_range(3) != 0) it.pc[1:0] = 2'b00;
    end else if ($urandom_range(4) == 0) begin
      it.word = SyscallWord;
    end
    case ($urandom_range(7))
      0, 1: ;
      2: case ($urandom_range(4))
           0:       it.rs_value = region_first;
           1:       it.rs_value = region_past;
           2:       it.rs_value = region_past - 32'd1;
           3:       it.rs_value = region_first - 32'd1;
           default: it.rs_value = region_first + $urandom_range(region_past - region_first);
         endcase
      3: it.rs_value = {16'h1000, 16'($urandom)};
      4: it.rs_value = {8'h1D, 24'($urandom)};
      5: it.rs_value = {8'h1C, 24'($urandom)};
      6: it.rs_value = {20'h1000F, 12'($urandom)};
      default: it.rs_value = {4'h1, 28'($urandom)};
    endcase
    // in half the cases put the function bounds around the destination, edges included
    case ($urandom_range(5))
      0, 1, 2: begin
        if (!flow_dest(it.pc, it.word, dest)) dest = it.pc;
        it.func_lo = dest - $urandom_range(64);
        it.func_hi = dest + $urandom_range(64);
      end
      3: begin
        it.func_lo = '0;
        it.func_hi = $urandom_range(16);
      end
      4: it.func_hi = it.func_lo;
      default: ;
    endcase
    return it;
  endfunction

  task automatic push_word(input item_t it, input result_t want);
    decode_rec_t rec;
    if (!steady_flow) begin
      while ($urandom_range(99) < 38) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    instr_pc_i   <= it.pc;
    instr_word_i <= it.word;
    func_lo_i    <= it.func_lo;
    func_hi_i    <= it.func_hi;
    rs_value_i   <= it.rs_value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rec.stim = it;
    rec.want = want;
    pending_decodes.insert(pending_decodes.size(), rec);
  endtask

  task automatic run_random(input int count);
    item_t it;
    repeat (count) begin
      it = forge_item();
      push_word(it, decode_word(it));
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_code_region(input logic [31:0] first, input logic [31:0] past);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgCodeStart;
    cfg_data_i  <= first;
    @(posedge clk_i);
    cfg_index_i <= CfgCodeEnd;
    cfg_data_i  <= past;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    region_first = first;
    region_past  = past;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin : result_check
    result_t     got;
    decode_rec_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.call_found         = call_found_o;
      got.call_addr          = call_addr_o;
      got.local_target_valid = local_target_valid_o;
      got.local_target       = local_target_o;
      got.syscall_found      = syscall_found_o;
      got.return_found       = return_found_o;
      got.mem_op             = mem_op_e'(mem_op_o);
      got.access_bytes       = access_bytes_o;
      got.effective_addr     = effective_addr_o;
      got.base_index         = base_index_o;
      got.io_region          = io_region_o;
      if (pending_decodes.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected word out: %s", fmt_result(got));
      end else begin
        head = pending_decodes.pop_front();
        if (got.call_found !== head.want.call_found
            || got.call_addr !== head.want.call_addr
            || got.local_target_valid !== head.want.local_target_valid
            || got.local_target !== head.want.local_target
            || got.syscall_found !== head.want.syscall_found
            || got.return_found !== head.want.return_found
            || got.mem_op !== head.want.mem_op
            || got.access_bytes !== head.want.access_bytes
            || got.effective_addr !== head.want.effective_addr
            || got.base_index !== head.want.base_index
            || got.io_region !== head.want.io_region) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch pc=%h word=%h lo=%h hi=%h rs=%h", head.stim.pc,
                     head.stim.word, head.stim.func_lo, head.stim.func_hi,
                     head.stim.rs_value);
            $display("  want %s", fmt_result(head.want));
            $display("  got  %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned drain_wait;
    logic [31:0] first;

    // empty code region from reset: jalr never counts as a call here
    add_row(32'h0040_0000, SyscallWord, 32'h0040_0000, 32'h0040_0100, '0, 1'b1,
            result_of(0, '0, 0, '0, 1, 0, MemNone, 3'd0, '0, '0, IoNone));
    add_row(32'h0040_0010, enc_reg(RegRa, RegZero, FnJr), '0, 32'h0000_0100, '0, 1'b1,
            result_of(0, '0, 1, '0, 0, 1, MemNone, 3'd0, '0, '0, IoNone));
    add_row(32'h0040_0020, enc_reg(5'd4, RegRa, FnJalr), 32'h0040_0000, 32'h0040_1000,
            32'h0040_0100, 1'b0, '0);
    add_row(32'h0040_0020, enc_reg(5'd4, 5'd5, FnJalr), '0, 32'h1, 32'h0040_0100, 1'b0, '0);
    add_row(32'hFFFF_FFFC, enc_jump(OpJal, 26'h3FF_FFFF), 32'hF000_0000, 32'hFFFF_FFFF,
            '0, 1'b1, result_of(1, 32'hFFFF_FFFC, 1, 32'hFFFF_FFFC, 0, 0, MemNone,
                                3'd0, '0, '0, IoNone));
    add_row('0, enc_jump(OpJal, '0), '0, '0, '0, 1'b1,
            result_of(1, '0, 0, '0, 0, 0, MemNone, 3'd0, '0, '0, IoNone));
    // jalx calls but never yields a local target
    add_row(32'h8000_1000, enc_jump(OpJalx, 26'h3FF_FFFF), '0, 32'hFFFF_FFFF, '0, 1'b1,
            result_of(1, 32'h8FFF_FFFC, 0, '0, 0, 0, MemNone, 3'd0, '0, '0, IoNone));
    add_row(32'h0040_0000, enc_jump(OpJ, 26'h10), '0, 32'h0000_0100, '0, 1'b0, '0);
    add_row(32'h0002_0000, enc_imm(OpBeq, 5'd0, 5'd0, 16'h8000), '0, 32'h0003_0000,
            '0, 1'b0, '0);
    add_row(32'h0000_1000, enc_imm(OpBne, 5'd1, 5'd2, 16'h0010), 32'h0000_2000,
            32'h0000_1000, '0, 1'b0, '0);
    add_row(32'h0000_1000, enc_imm(OpBlez, 5'd3, 5'd0, 16'h0001), 32'h0000_1008,
            32'h0000_1008, '0, 1'b0, '0);
    add_row(32'hFFFF_FFF0, enc_imm(OpBgtz, 5'd1, 5'd0, 16'h7FFF), 32'h0001_0000,
            32'h0002_0000, '0, 1'b0, '0);
    add_row(32'h0000_0100, enc_imm(OpRegimm, 5'd2, RtBgezall, 16'h0004), 32'h0000_0100,
            32'h0000_0200, '0, 1'b0, '0);
    add_row(32'h0000_1000, enc_imm(OpSpecial2, 5'd0, 5'd0, {10'd0, FnS2Branch}),
            32'h0000_1000, 32'h0000_100C, '0, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLb, RegRa, 5'd2, 16'h0000), 32'h0040_0000,
            32'h0040_0100, 32'h1000_0000, 1'b1,
            result_of(0, '0, 0, '0, 0, 0, MemLoad, 3'd1, 32'h1000_0000, RegRa, IoWin1));
    add_row(32'h0040_0000, enc_imm(OpLh, 5'd0, 5'd1, 16'h8000), 32'h0040_0000,
            32'h0040_0100, '0, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLwl, 5'd31, 5'd31, 16'h0000), 32'h0040_0000,
            32'h0040_0100, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLw, 5'd8, 5'd9, 16'h0123), 32'h0040_0000,
            32'h0040_0100, 32'h1D12_3000, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLbu, 5'd5, RegZero, 16'hFFFF), 32'h0040_0000,
            32'h0040_0100, 32'h1D00_0000, 1'b1,
            result_of(0, '0, 0, '0, 0, 0, MemLoad, 3'd1, 32'h1CFF_FFFF, 5'd5, IoWin4));
    add_row(32'h0040_0000, enc_imm(OpLhu, 5'd6, 5'd7, 16'h0000), 32'h0040_0000,
            32'h0040_0100, 32'h1000_F100, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLwr, 5'd10, 5'd11, 16'h0001), 32'h0040_0000,
            32'h0040_0100, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLl, 5'd12, 5'd13, 16'hFFFF), 32'h0040_0000,
            32'h0040_0100, 32'h1C00_0000, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpLd, 5'd14, 5'd15, 16'h0010), 32'h0040_0000,
            32'h0040_0100, 32'h1000_2000, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpSb, 5'd16, 5'd17, 16'h0000), 32'h0040_0000,
            32'h0040_0100, 32'h1000_F1FF, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpSh, 5'd18, 5'd19, 16'h0000), 32'h0040_0000,
            32'h0040_0100, 32'h1000_5000, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpSwl, 5'd20, 5'd21, 16'h0001), 32'h0040_0000,
            32'h0040_0100, 32'h0FFF_FFFF, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpSw, 5'd29, RegRa, 16'h7FFF), 32'h0040_0000,
            32'h0040_0100, 32'h1D00_0000, 1'b1,
            result_of(0, '0, 0, '0, 0, 0, MemStore, 3'd4, 32'h1D00_7FFF, 5'd29, IoWin3));
    add_row(32'h0040_0000, enc_imm(OpSq, 5'd22, 5'd23, 16'h0001), 32'h0040_0000,
            32'h0040_0100, 32'h1DFF_FFFF, 1'b0, '0);
    add_row(32'h0040_0000, enc_imm(OpSdc2, 5'd24, 5'd25, 16'hFFFF), 32'h0040_0000,
            32'h0040_0100, 32'h1C00_0000, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) push_word(plan[i].stim, plan[i].typed ? plan[i].want
                                                            : decode_word(plan[i].stim));
    run_random(150);

    settle();
    set_code_region(32'h0040_0000, 32'h0080_0000);
    run_random(300);

    // full code region, both sides streaming with no gaps
    settle();
    set_code_region('0, 32'hFFFF_FFFF);
    steady_flow = 1'b1;
    run_random(200);
    steady_flow = 1'b0;

    settle();
    set_code_region(32'hFFFF_FFFF, '0);
    run_random(150);

    settle();
    set_code_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(150);

    repeat (2) begin
      settle();
      first = $urandom;
      set_code_region(first, first + $urandom_range(32'h0010_0000));
      run_random(175);
    end

    in_valid_i <= 1'b0;
    drain_wait = 0;
    while (pending_decodes.size() != 0 && drain_wait < 5000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (4) @(posedge clk_i);
    fault_count += pending_decodes.size();
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mipd_pkg.sv
src/mipd_decode.sv
src/mips_instruction_predecoder_core.sv
test/testbench.sv
